[hdl/ghgs_pkg.sv]
`timescale 1ns / 1ps

package ghgs_pkg;

    localparam int GRID_HALF_MAX   = 64;
    localparam int COORD_FRAC_BITS = 7;
    localparam int GRID_SIDE       = 2 * GRID_HALF_MAX;
    localparam int GRID_CELLS      = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W          = $clog2(GRID_SIDE);
    localparam int ADDR_W          = $clog2(GRID_CELLS);

    localparam int COORD_W    = 16;
    localparam int IDX_W      = COORD_W + 2;
    localparam int HALF_W     = 7;
    localparam int DIFF_W     = 15;
    localparam int HEIGHT_W   = 16;
    localparam int OUT_CELL_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_HALF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWEST_THR = 2'd2;

    localparam logic [HALF_W-1:0]         GRID_HALF_RST  = 7'd32;
    localparam logic [DIFF_W-1:0]         DIFF_THR_RST   = 15'd26;
    localparam logic signed [COORD_W-1:0] LOWEST_THR_RST = -16'sd218;

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_LABEL = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        LBL_GROUND   = 2'd0,
        LBL_OBSTACLE = 2'd1,
        LBL_EMPTY    = 2'd2,
        LBL_OUTSIDE  = 2'd3
    } label_t;

    typedef struct packed {
        logic                      occ;
        logic signed [COORD_W-1:0] max_z;
        logic signed [COORD_W-1:0] min_z;
    } cell_word_t;

    typedef struct packed {
        logic              in_grid;
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [ADDR_W-1:0] addr;
    } loc_t;

    typedef struct packed {
        op_t                       op;
        logic                      in_grid;
        logic signed [COORD_W-1:0] z;
        logic [CELL_W-1:0]         cx;
        logic [CELL_W-1:0]         cy;
        logic [ADDR_W-1:0]         addr;
    } s1_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        cell_word_t        word;
    } wr_t;

    typedef struct packed {
        label_t                label;
        logic [HEIGHT_W-1:0]   height;
        logic [OUT_CELL_W-1:0] cell_x;
        logic [OUT_CELL_W-1:0] cell_y;
    } res_t;

endpackage

[hdl/ghgs_if.sv]
`timescale 1ns / 1ps

interface ghgs_point_if;
    import ghgs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic                      point_missing;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;

    modport source (output valid, opcode, point_missing, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, opcode, point_missing, pos_x, pos_y, pos_z, output ready);
endinterface

interface ghgs_result_if;
    import ghgs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            label;
    logic [HEIGHT_W-1:0]   height_over_min;
    logic [OUT_CELL_W-1:0] cell_x;
    logic [OUT_CELL_W-1:0] cell_y;

    modport source (output valid, label, height_over_min, cell_x, cell_y, input ready);
    modport sink   (input valid, label, height_over_min, cell_x, cell_y, output ready);
endinterface

[hdl/grid_height_ground_segmenter_core.sv]
`timescale 1ns / 1ps

// channel  | dir | handshake   | payload
// points   | in  | valid/ready | opcode, point_missing, pos_x, pos_y, pos_z
// results  | out | valid/ready | label, height_over_min, cell_x, cell_y
// cfg      | in  | cfg_we      | cfg_index, cfg_data
//
// one item per cycle unless stalled: cell read at accept, written back in update stage
// a label result enters the output register when its item leaves the update stage
// after reset a clearing pass over all 16384 cells holds points.ready low
// a stalled result holds the next label item in the update stage, which stops intake

module grid_height_ground_segmenter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    ghgs_point_if.sink                       points,
    ghgs_result_if.source                    results,
    input  logic                             cfg_we,
    input  logic [ghgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ghgs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ghgs_pkg::*;

    logic [HALF_W-1:0]         grid_half_reg;
    logic [DIFF_W-1:0]         diff_thr_reg;
    logic signed [COORD_W-1:0] lowest_thr_reg;

    logic              s1_valid_reg;
    s1_t               s1_reg;
    logic [ADDR_W-1:0] clear_idx_reg;
    logic              out_valid_reg;
    res_t              res_reg;

    loc_t       loc;
    cell_word_t cell_word;
    wr_t        wr;
    wr_t        wr_raw;
    res_t       res;
    logic       has_res;
    logic       busy;
    logic       accept;
    logic       s1_fire;

    ghgs_locate u_locate (
        .point_missing (points.point_missing),
        .pos_x         (points.pos_x),
        .pos_y         (points.pos_y),
        .grid_half     (grid_half_reg),
        .loc           (loc)
    );

    ghgs_cell_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (loc.addr),
        .wr      (wr),
        .rd_word (cell_word),
        .busy    (busy)
    );

    ghgs_update u_update (
        .s1         (s1_reg),
        .word       (cell_word),
        .diff_thr   (diff_thr_reg),
        .lowest_thr (lowest_thr_reg),
        .clear_idx  (clear_idx_reg),
        .wr         (wr_raw),
        .res        (res),
        .has_res    (has_res)
    );

    // label items wait while the output register is still full and results.ready is low
    assign s1_fire       = s1_valid_reg && (!has_res || !out_valid_reg || results.ready);
    assign points.ready  = !busy && (!s1_valid_reg || s1_fire);
    assign accept        = points.valid && points.ready;

    always_comb
    begin
        wr    = wr_raw;
        wr.en = wr_raw.en && s1_fire;
    end

    assign results.valid           = out_valid_reg;
    assign results.label           = res_reg.label;
    assign results.height_over_min = res_reg.height;
    assign results.cell_x          = res_reg.cell_x;
    assign results.cell_y          = res_reg.cell_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_half_reg  <= GRID_HALF_RST;
            diff_thr_reg   <= DIFF_THR_RST;
            lowest_thr_reg <= LOWEST_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_HALF:  grid_half_reg  <= cfg_data[HALF_W-1:0];
                REG_DIFF_THR:   diff_thr_reg   <= cfg_data[DIFF_W-1:0];
                REG_LOWEST_THR: lowest_thr_reg <= signed'(cfg_data[COORD_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            clear_idx_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire && has_res)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_fire && (s1_reg.op == OP_CLEAR))
            begin
                if (clear_idx_reg == ADDR_W'(GRID_CELLS - 1))
                begin
                    clear_idx_reg <= '0;
                end
                else
                begin
                    clear_idx_reg <= clear_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.op      <= op_t'(points.opcode);
            s1_reg.in_grid <= loc.in_grid;
            s1_reg.z       <= points.pos_z;
            s1_reg.cx      <= loc.cx;
            s1_reg.cy      <= loc.cy;
            s1_reg.addr    <= loc.addr;
        end
        if (s1_fire && has_res)
        begin
            res_reg <= res;
        end
    end
endmodule

[hdl/ghgs_locate.sv]
`timescale 1ns / 1ps

module ghgs_locate (
    input  logic                                point_missing,
    input  logic signed [ghgs_pkg::COORD_W-1:0] pos_x,
    input  logic signed [ghgs_pkg::COORD_W-1:0] pos_y,
    input  logic [ghgs_pkg::HALF_W-1:0]         grid_half,
    output ghgs_pkg::loc_t                      loc
);
    import ghgs_pkg::*;

    logic signed [IDX_W-1:0] fx;
    logic signed [IDX_W-1:0] fy;
    logic signed [IDX_W-1:0] half;
    logic signed [IDX_W-1:0] side;
    logic signed [IDX_W-1:0] ix;
    logic signed [IDX_W-1:0] iy;
    logic [IDX_W-1:0]        half_ext;

    // arithmetic shift is floor for negative coordinates too
    assign fx       = IDX_W'(pos_x >>> COORD_FRAC_BITS);
    assign fy       = IDX_W'(pos_y >>> COORD_FRAC_BITS);
    assign half_ext = IDX_W'(grid_half);
    assign half     = (half_ext > IDX_W'(GRID_HALF_MAX)) ? IDX_W'(GRID_HALF_MAX)
                                                         : signed'(half_ext);
    assign side     = half <<< 1;
    assign ix       = fx + half;
    assign iy       = fy + half;

    always_comb
    begin
        loc.in_grid = !point_missing && (ix >= 0) && (iy >= 0) && (ix < side) && (iy < side);
        loc.cx      = ix[CELL_W-1:0];
        loc.cy      = iy[CELL_W-1:0];
        loc.addr    = ADDR_W'(ADDR_W'(ix[CELL_W-1:0]) * ADDR_W'(GRID_SIDE)
                              + ADDR_W'(iy[CELL_W-1:0]));
    end
endmodule

[hdl/ghgs_cell_store.sv]
`timescale 1ns / 1ps

module ghgs_cell_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [ghgs_pkg::ADDR_W-1:0] rd_addr,
    input  ghgs_pkg::wr_t               wr,
    output ghgs_pkg::cell_word_t        rd_word,
    output logic                        busy
);
    import ghgs_pkg::*;

    cell_word_t        mem [GRID_CELLS];
    cell_word_t        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic              busy_reg;
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    cell_word_t        fwd_word_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    cell_word_t        mem_word;

    // the clearing pass after reset owns the write port
    assign mem_we   = busy_reg || wr.en;
    assign mem_addr = busy_reg ? sweep_cnt_reg : wr.addr;
    assign mem_word = busy_reg ? cell_word_t'('0) : wr.word;
    assign busy     = busy_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (mem_we)
        begin
            fwd_addr_reg <= mem_addr;
            fwd_word_reg <= mem_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            sweep_cnt_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (busy_reg)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == ADDR_W'(GRID_CELLS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // the last write may land on the entry read at the same edge
    assign rd_word = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_word_reg
                                                                       : rd_data_reg;
endmodule

[hdl/ghgs_update.sv]
`timescale 1ns / 1ps

module ghgs_update (
    input  ghgs_pkg::s1_t                       s1,
    input  ghgs_pkg::cell_word_t                word,
    input  logic [ghgs_pkg::DIFF_W-1:0]         diff_thr,
    input  logic signed [ghgs_pkg::COORD_W-1:0] lowest_thr,
    input  logic [ghgs_pkg::ADDR_W-1:0]         clear_idx,
    output ghgs_pkg::wr_t                       wr,
    output ghgs_pkg::res_t                      res,
    output logic                                has_res
);
    import ghgs_pkg::*;

    logic signed [COORD_W:0] spread;
    logic signed [COORD_W:0] above;
    logic                    obstacle;

    assign spread   = $signed({word.max_z[COORD_W-1], word.max_z})
                    - $signed({word.min_z[COORD_W-1], word.min_z});
    assign above    = $signed({s1.z[COORD_W-1], s1.z})
                    - $signed({word.min_z[COORD_W-1], word.min_z});
    assign obstacle = (spread > $signed({2'b00, diff_thr})) || (word.min_z > lowest_thr);

    always_comb
    begin
        wr.en      = 1'b0;
        wr.addr    = s1.addr;
        wr.word    = word;
        res.label  = LBL_OUTSIDE;
        res.height = '0;
        res.cell_x = '0;
        res.cell_y = '0;
        has_res    = 1'b0;
        case (s1.op)
            OP_ACC:
            begin
                if (s1.in_grid)
                begin
                    wr.en       = 1'b1;
                    wr.word.occ = 1'b1;
                    if (!word.occ || (s1.z < word.min_z))
                    begin
                        wr.word.min_z = s1.z;
                    end
                    if (!word.occ || (s1.z > word.max_z))
                    begin
                        wr.word.max_z = s1.z;
                    end
                end
            end
            OP_LABEL:
            begin
                has_res = 1'b1;
                if (s1.in_grid)
                begin
                    res.cell_x = OUT_CELL_W'(s1.cx);
                    res.cell_y = OUT_CELL_W'(s1.cy);
                    if (!word.occ)
                    begin
                        res.label = LBL_EMPTY;
                    end
                    else
                    begin
                        res.label  = obstacle ? LBL_OBSTACLE : LBL_GROUND;
                        // point below the cell minimum reads as zero height
                        res.height = above[COORD_W] ? '0 : above[HEIGHT_W-1:0];
                    end
                end
            end
            OP_CLEAR:
            begin
                wr.en   = 1'b1;
                wr.addr = clear_idx;
                wr.word = '0;
            end
            default:
            begin
            end
        endcase
    end
endmodule

[hdl/ghgs_checker.sv]
`timescale 1ns / 1ps

module ghgs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [1:0]                      in_opcode,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [1:0]                      out_label,
    input logic [ghgs_pkg::HEIGHT_W-1:0]   out_height,
    input logic [ghgs_pkg::OUT_CELL_W-1:0] out_cell_x,
    input logic [ghgs_pkg::OUT_CELL_W-1:0] out_cell_y
);
    import ghgs_pkg::*;

    // a fresh result comes from a label item accepted into the update stage and then the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && (in_opcode == OP_LABEL), 2))
        else $error("result without a matching label item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_label == LBL_OUTSIDE))
            |-> ((out_cell_x == '0) && (out_cell_y == '0) && (out_height == '0)))
        else $error("outside result carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_label == LBL_EMPTY)) |-> (out_height == '0))
        else $error("empty cell result carries a height");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_label) && $stable(out_height)))
        else $error("stalled result changed");

endmodule

bind grid_height_ground_segmenter_core ghgs_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (points.valid),
    .in_ready   (points.ready),
    .in_opcode  (points.opcode),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_label  (results.label),
    .out_height (results.height_over_min),
    .out_cell_x (results.cell_x),
    .out_cell_y (results.cell_y)
);
